// ===== rtl/bcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdc_pkg
// Digit types, event codes and BCD carry/borrow helpers shared by the
// 24-hour clock and timer counter.
// ----------------------------------------------------------------------------
package bcdc_pkg;

  // six BCD digits of one HH:MM:SS set
  typedef struct packed {
    logic [1:0] ht;
    logic [3:0] hu;
    logic [2:0] mt;
    logic [3:0] mu;
    logic [2:0] st;
    logic [3:0] su;
  } digits_t;

  localparam int unsigned OP_W      = 4;
  localparam int unsigned TDATA_W   = 24;

  typedef logic [OP_W-1:0] op_t;

  // input event codes
  localparam op_t OP_CLK_SEC_UP = 4'd0;
  localparam op_t OP_CLK_MIN_UP = 4'd1;
  localparam op_t OP_CLK_HR_UP  = 4'd2;
  localparam op_t OP_CLK_MIN_DN = 4'd3;
  localparam op_t OP_CLK_HR_DN  = 4'd4;
  localparam op_t OP_CNT_SEC_UP = 4'd5;
  localparam op_t OP_CNT_SEC_DN = 4'd6;
  localparam op_t OP_CNT_MIN_DN = 4'd7;
  localparam op_t OP_CNT_HR_DN  = 4'd8;
  localparam op_t OP_CNT_LOAD   = 4'd9;
  localparam op_t OP_CLK_CLR    = 4'd10;
  localparam op_t OP_CNT_CLR    = 4'd11;

  // per-set action codes
  typedef logic [3:0] act_t;

  localparam act_t ACT_NONE   = 4'd0;
  localparam act_t ACT_SEC_UP = 4'd1;
  localparam act_t ACT_MIN_UP = 4'd2;
  localparam act_t ACT_HR_UP  = 4'd3;
  localparam act_t ACT_SEC_DN = 4'd4;
  localparam act_t ACT_MIN_DN = 4'd5;
  localparam act_t ACT_HR_DN  = 4'd6;
  localparam act_t ACT_LOAD   = 4'd7;
  localparam act_t ACT_CLR    = 4'd8;

  function automatic digits_t hr_up(digits_t d);
    digits_t r;
    r = d;
    if (d.hu < 4'd9 && d.ht < 2'd2) begin
      r.hu = d.hu + 4'd1;
    end else if (d.hu == 4'd9 && d.ht < 2'd2) begin
      r.hu = 4'd0;
      r.ht = d.ht + 2'd1;
    end else if (d.ht == 2'd2 && d.hu < 4'd3) begin
      r.hu = d.hu + 4'd1;
    end else begin
      // past 23 hours, or nonsense digits: whole set back to zero
      r = '0;
    end
    return r;
  endfunction

  function automatic digits_t min_up(digits_t d);
    digits_t r;
    r = d;
    if (d.mu < 4'd9) begin
      r.mu = d.mu + 4'd1;
    end else begin
      r.mu = 4'd0;
      if (d.mt < 3'd5) begin
        r.mt = d.mt + 3'd1;
      end else begin
        r.mt = 3'd0;
        r = hr_up(r);
      end
    end
    return r;
  endfunction

  function automatic digits_t sec_up(digits_t d);
    digits_t r;
    r = d;
    if (d.su < 4'd9) begin
      r.su = d.su + 4'd1;
    end else begin
      r.su = 4'd0;
      if (d.st < 3'd5) begin
        r.st = d.st + 3'd1;
      end else begin
        r.st = 3'd0;
        r = min_up(r);
      end
    end
    return r;
  endfunction

  function automatic digits_t hr_dn(digits_t d);
    digits_t r;
    r = d;
    if (d.hu != 4'd0) begin
      r.hu = d.hu - 4'd1;
    end else if (d.ht != 2'd0) begin
      r.hu = 4'd9;
      r.ht = d.ht - 2'd1;
    end else begin
      // below 00 hours wraps to 23
      r.ht = 2'd2;
      r.hu = 4'd3;
    end
    return r;
  endfunction

  function automatic digits_t min_dn(digits_t d);
    digits_t r;
    r = d;
    if (d.mu != 4'd0) begin
      r.mu = d.mu - 4'd1;
    end else begin
      r.mu = 4'd9;
      if (d.mt != 3'd0) begin
        r.mt = d.mt - 3'd1;
      end else begin
        r.mt = 3'd5;
        r = hr_dn(r);
      end
    end
    return r;
  endfunction

  function automatic digits_t sec_dn(digits_t d);
    digits_t r;
    r = d;
    if (d.su != 4'd0) begin
      r.su = d.su - 4'd1;
    end else begin
      r.su = 4'd9;
      if (d.st != 3'd0) begin
        r.st = d.st - 3'd1;
      end else begin
        r.st = 3'd5;
        r = min_dn(r);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bcdc_set_step.sv =====
// ----------------------------------------------------------------------------
// bcdc_set_step
// Next-value logic for one six-digit time set under one action.
// ----------------------------------------------------------------------------
module bcdc_set_step
  import bcdc_pkg::*;
(
  input  act_t    act,
  input  digits_t cur,
  input  digits_t load,
  output digits_t nxt
);

  always_comb begin
    unique case (act)
      ACT_SEC_UP: nxt = sec_up(cur);
      ACT_MIN_UP: nxt = min_up(cur);
      ACT_HR_UP:  nxt = hr_up(cur);
      ACT_SEC_DN: nxt = sec_dn(cur);
      ACT_MIN_DN: nxt = min_dn(cur);
      ACT_HR_DN:  nxt = hr_dn(cur);
      ACT_LOAD:   nxt = load;
      ACT_CLR:    nxt = '0;
      default:    nxt = cur;
    endcase
  end

endmodule

// ===== rtl/bcd_clock_and_timer_counter.sv =====
// ----------------------------------------------------------------------------
// bcd_clock_and_timer_counter
// Two 24-hour BCD HH:MM:SS sets (time of day and timer counter) stepped by
// events; each event returns the six digits of the set it touched.
// ----------------------------------------------------------------------------
//  channel | direction | tdata                         | tuser
//  --------+-----------+-------------------------------+------------------
//  in_     | slave     | armed flag and load digits    | op (event code)
//  out_    | master    | six digits of the touched set | shows_counter
//
//  A result passes an input register, then one pass of BCD carry/borrow logic
//  into the result register. One item per cycle is sustained while out_tready
//  is high; the time-set registers loop back through the step logic.
//  Reset clears both time sets and the valid flags; no clearing pass.
//  A stalled result holds the result register; the input register still takes
//  an item while it is empty, and in_tready follows out_tready otherwise.
// ----------------------------------------------------------------------------
module bcd_clock_and_timer_counter
  import bcdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // [0] timer_armed, [2:1] load_hour_tens, [6:3] load_hour_units,
  // [9:7] load_minute_tens, [13:10] load_minute_units,
  // [16:14] load_second_tens, [20:17] load_second_units, [23:21] zero
  input  logic [TDATA_W-1:0] in_tdata,
  // [3:0] op
  input  logic [OP_W-1:0]    in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  // [1:0] hour_tens, [5:2] hour_units, [8:6] minute_tens,
  // [12:9] minute_units, [15:13] second_tens, [19:16] second_units,
  // [23:20] zero
  output logic [TDATA_W-1:0] out_tdata,
  // [0] shows_counter
  output logic [0:0]         out_tuser
);

  // input register
  logic    in_valid_r;
  op_t     in_op_r;
  logic    in_armed_r;
  digits_t in_load_r;

  // time sets
  digits_t clock_r,   clock_nxt;
  digits_t counter_r, counter_nxt;

  // result register
  logic    out_valid_r;
  logic    out_sel_r;
  digits_t out_digits_r;

  logic    adv;
  act_t    clk_act;
  act_t    cnt_act;
  logic    sel;
  digits_t load_in;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign load_in.ht = in_tdata[2:1];
  assign load_in.hu = in_tdata[6:3];
  assign load_in.mt = in_tdata[9:7];
  assign load_in.mu = in_tdata[13:10];
  assign load_in.st = in_tdata[16:14];
  assign load_in.su = in_tdata[20:17];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r    <= in_tuser;
      in_armed_r <= in_tdata[0];
      in_load_r  <= load_in;
    end
  end

  // event decode into one action per set
  always_comb begin
    clk_act = ACT_NONE;
    cnt_act = ACT_NONE;
    sel     = 1'b0;
    unique case (in_op_r)
      OP_CLK_SEC_UP: clk_act = ACT_SEC_UP;
      OP_CLK_MIN_UP: clk_act = ACT_MIN_UP;
      OP_CLK_HR_UP:  clk_act = ACT_HR_UP;
      OP_CLK_MIN_DN: clk_act = ACT_MIN_DN;
      OP_CLK_HR_DN:  clk_act = ACT_HR_DN;
      OP_CLK_CLR:    clk_act = ACT_CLR;
      OP_CNT_SEC_UP: begin
        cnt_act = ACT_SEC_UP;
        sel     = 1'b1;
      end
      OP_CNT_SEC_DN: begin
        // seconds only count down while the timer is armed
        cnt_act = in_armed_r ? ACT_SEC_DN : ACT_NONE;
        sel     = 1'b1;
      end
      OP_CNT_MIN_DN: begin
        cnt_act = ACT_MIN_DN;
        sel     = 1'b1;
      end
      OP_CNT_HR_DN: begin
        cnt_act = ACT_HR_DN;
        sel     = 1'b1;
      end
      OP_CNT_LOAD: begin
        cnt_act = ACT_LOAD;
        sel     = 1'b1;
      end
      OP_CNT_CLR: begin
        cnt_act = ACT_CLR;
        sel     = 1'b1;
      end
      default: begin
        // unused codes leave both sets alone and show the clock
        clk_act = ACT_NONE;
        cnt_act = ACT_NONE;
        sel     = 1'b0;
      end
    endcase
  end

  bcdc_set_step u_clock_step (
    .act  (clk_act),
    .cur  (clock_r),
    .load (in_load_r),
    .nxt  (clock_nxt)
  );

  bcdc_set_step u_counter_step (
    .act  (cnt_act),
    .cur  (counter_r),
    .load (in_load_r),
    .nxt  (counter_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_r   <= '0;
      counter_r <= '0;
    end else if (adv) begin
      clock_r   <= clock_nxt;
      counter_r <= counter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sel_r    <= sel;
      out_digits_r <= sel ? counter_nxt : clock_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tuser[0] = out_sel_r;
  assign out_tdata    = {4'd0,
                         out_digits_r.su, out_digits_r.st,
                         out_digits_r.mu, out_digits_r.mt,
                         out_digits_r.hu, out_digits_r.ht};

  // the clock set only ever holds legal time digits
  assert property (@(posedge clk) disable iff (!rst_n)
    clock_r.ht <= 2'd2 && clock_r.hu <= 4'd9 && clock_r.mt <= 3'd5 &&
    clock_r.mu <= 4'd9 && clock_r.st <= 3'd5 && clock_r.su <= 4'd9 &&
    !(clock_r.ht == 2'd2 && clock_r.hu > 4'd3))
    else $error("clock set holds an illegal digit");

  // an empty result register never holds off the input side
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  // a clear of the clock leaves it at zero
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_op_r == OP_CLK_CLR) |=> clock_r == '0)
    else $error("clock not cleared");

  // a load puts the requested digits into the counter
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_op_r == OP_CNT_LOAD) |=> counter_r == $past(in_load_r))
    else $error("counter load mismatch");

endmodule
